@@ design/k_way_sorted_merge_core_defines.svh @@
// Assertion macros shared by the merge core
`ifndef K_WAY_SORTED_MERGE_CORE_DEFINES_SVH
`define K_WAY_SORTED_MERGE_CORE_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define KWM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger
`define KWM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/kwm_pkg.sv @@
`default_nettype none
package kwm_pkg;

    // Sizing
    localparam int LISTS      = 8;
    localparam int LIST_DEPTH = 64;
    localparam int VALUE_BITS = 32;

    localparam int ID_W    = (LISTS > 1) ? $clog2(LISTS) : 1;
    localparam int CNT_W   = $clog2(LIST_DEPTH + 1);
    localparam int ADDR_W  = $clog2(LISTS * LIST_DEPTH);
    localparam int LCNT_W  = $clog2(LISTS + 1);
    localparam int LN_W    = (LCNT_W > 4) ? LCNT_W : 4;

    // Operation codes
    localparam logic [1:0] OP_APPEND = 2'd0;
    localparam logic [1:0] OP_POP    = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_BAD_LIST = 2'd3;

    localparam logic [3:0] ACTIVE_RESET = 4'd8;

    typedef enum logic {
        S_IDLE,
        S_REFILL
    } state_t;

endpackage
`default_nettype wire

@@ design/kwm_ifs.sv @@
`default_nettype none

// Request word: operation, list and value
interface kwm_req_if;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic [2:0]        list_id;
    logic signed [31:0] value;

    modport source (output valid, output opcode, output list_id, output value, input ready);
    modport sink   (input valid, input opcode, input list_id, input value, output ready);
endinterface

// Response word: popped value, its list and a status
interface kwm_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] value_out;
    logic [2:0]         source_list;
    logic [1:0]         status;

    modport source (output valid, output value_out, output source_list, output status,
                    input ready);
    modport sink   (input valid, input value_out, input source_list, input status,
                    output ready);
endinterface

// Configuration write word: active list count
interface kwm_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ design/k_way_sorted_merge_core.sv @@
// K-way merge core.
// Channels: req carries one word per operation (append a value to a list, pop the
// smallest head over the active lists, clear all lists); rsp returns exactly one
// word per request with value_out, source_list and status; cfg writes the active
// list count at any time the core is idle (always ready).
// The response is registered and shows in the cycle after the request is taken.
// Appends, clears and pops that empty their list keep the core in S_IDLE for the next
// request; a pop that leaves its list non-empty first passes through S_REFILL, since
// the new head of that list is read from the element memory through its single read
// port and loaded into the head register before the next request.
// Heads of all lists sit in registers and feed a compare chain, so a pop needs no
// memory read before its answer.
// Reset clears the list counters and sets the active list count to ACTIVE_RESET (8, all lists);
// element memory is not cleared, only entries below a list's fill count are read.
// A stalled receiver holds the response; one new request is still taken in the
// cycle the waiting response is taken, otherwise req.ready stays low.
`default_nettype none
`include "k_way_sorted_merge_core_defines.svh"

module k_way_sorted_merge_core
    import kwm_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    kwm_req_if.sink     req,
    kwm_rsp_if.source   rsp,
    kwm_cfg_if.sink     cfg
);

    // Element memory
    logic [VALUE_BITS-1:0] mem [LISTS*LIST_DEPTH];
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [VALUE_BITS-1:0] mem_rdata_reg;

    // Control state
    state_t          state_reg, state_next;
    logic [3:0]      active_reg, active_next;
    logic [CNT_W-1:0] cnt_reg [LISTS];
    logic [CNT_W-1:0] cnt_next [LISTS];
    logic [CNT_W-1:0] pop_reg [LISTS];
    logic [CNT_W-1:0] pop_next [LISTS];
    logic            rsp_valid_reg, rsp_valid_next;

    // Payload state
    logic [VALUE_BITS-1:0] head_reg [LISTS];
    logic [VALUE_BITS-1:0] head_next [LISTS];
    logic [ID_W-1:0]       refill_id_reg, refill_id_next;
    logic [31:0]           rsp_value_reg, rsp_value_next;
    logic [2:0]            rsp_src_reg, rsp_src_next;
    logic [1:0]            rsp_status_reg, rsp_status_next;

    logic                  req_fire;
    logic [LN_W-1:0]       live_n;
    logic [VALUE_BITS-1:0] req_val;
    logic [ID_W-1:0]       req_idx;
    logic                  found;
    logic [ID_W-1:0]       best;
    logic [VALUE_BITS-1:0] best_val;
    logic [LISTS-1:0]      nonempty;
    logic                  refill_need;
    logic                  counts_ok;

    assign req.ready     = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign req_fire      = req.valid && req.ready;
    assign cfg.ready     = 1'b1;
    assign rsp.valid     = rsp_valid_reg;
    assign rsp.value_out = rsp_value_reg;
    assign rsp.source_list = rsp_src_reg;
    assign rsp.status    = rsp_status_reg;

    assign live_n  = (LN_W'(active_reg) > LN_W'(LISTS)) ? LN_W'(LISTS) : LN_W'(active_reg);
    assign req_val = VALUE_BITS'(req.value);
    assign req_idx = ID_W'(req.list_id);

    // Find the smallest head; later lists win ties
    always_comb
    begin
        found    = 1'b0;
        best     = '0;
        best_val = '0;
        for (int i = 0; i < LISTS; i++)
        begin
            nonempty[i] = (LN_W'(i) < live_n) && (pop_reg[i] < cnt_reg[i]);
            if (nonempty[i] && (!found || $signed(head_reg[i]) <= $signed(best_val)))
            begin
                found    = 1'b1;
                best     = ID_W'(i);
                best_val = head_reg[i];
            end
        end
    end

    assign refill_need = found && (CNT_W'(pop_reg[best] + 1'b1) < cnt_reg[best]);

    // Next state, memory access and response
    always_comb
    begin
        state_next      = state_reg;
        active_next     = active_reg;
        cnt_next        = cnt_reg;
        pop_next        = pop_reg;
        head_next       = head_reg;
        refill_id_next  = refill_id_reg;
        rsp_value_next  = rsp_value_reg;
        rsp_src_next    = rsp_src_reg;
        rsp_status_next = rsp_status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        mem_we          = 1'b0;
        mem_waddr       = ADDR_W'(req_idx) * ADDR_W'(LIST_DEPTH) + ADDR_W'(cnt_reg[req_idx]);
        mem_wdata       = req_val;
        mem_re          = 1'b0;
        mem_raddr       = ADDR_W'(best) * ADDR_W'(LIST_DEPTH)
                          + ADDR_W'(CNT_W'(pop_reg[best] + 1'b1));

        if (cfg.valid)
        begin
            active_next = cfg.data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_value_next  = '0;
                    rsp_src_next    = '0;
                    rsp_status_next = ST_OK;
                    case (req.opcode)
                        OP_APPEND:
                        begin
                            if (LN_W'(req.list_id) >= live_n)
                            begin
                                rsp_status_next = ST_BAD_LIST;
                            end
                            else if (cnt_reg[req_idx] >= CNT_W'(LIST_DEPTH))
                            begin
                                rsp_status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                // load the head directly when the list was empty
                                if (pop_reg[req_idx] == cnt_reg[req_idx])
                                begin
                                    head_next[req_idx] = req_val;
                                end
                                cnt_next[req_idx] = CNT_W'(cnt_reg[req_idx] + 1'b1);
                            end
                        end
                        OP_POP:
                        begin
                            if (!found)
                            begin
                                rsp_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rsp_value_next = 32'(best_val);
                                rsp_src_next   = 3'(best);
                                pop_next[best] = CNT_W'(pop_reg[best] + 1'b1);
                                if (refill_need)
                                begin
                                    mem_re         = 1'b1;
                                    refill_id_next = best;
                                    state_next     = S_REFILL;
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            for (int i = 0; i < LISTS; i++)
                            begin
                                cnt_next[i] = '0;
                                pop_next[i] = '0;
                            end
                        end
                        default:
                        begin
                            rsp_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_REFILL:
            begin
                // take the new head of the popped list
                head_next[refill_id_reg] = mem_rdata_reg;
                state_next               = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= mem[mem_raddr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= ACTIVE_RESET;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < LISTS; i++)
            begin
                cnt_reg[i] <= '0;
                pop_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            rsp_valid_reg <= rsp_valid_next;
            cnt_reg       <= cnt_next;
            pop_reg       <= pop_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        head_reg       <= head_next;
        refill_id_reg  <= refill_id_next;
        rsp_value_reg  <= rsp_value_next;
        rsp_src_reg    <= rsp_src_next;
        rsp_status_reg <= rsp_status_next;
    end

    // No list has popped beyond its fill, and no fill exceeds the list depth
    always_comb
    begin
        counts_ok = 1'b1;
        for (int i = 0; i < LISTS; i++)
        begin
            if ((pop_reg[i] > cnt_reg[i]) || (cnt_reg[i] > CNT_W'(LIST_DEPTH)))
            begin
                counts_ok = 1'b0;
            end
        end
    end

    `KWM_ASSERT_SAME(a_no_req_in_refill, clk, rst_n, state_reg == S_REFILL, !req.ready, "request taken during head refill")
    `KWM_ASSERT_NEXT(a_refill_follows_pop, clk, rst_n, req_fire && req.opcode == OP_POP && refill_need, state_reg == S_REFILL && !rsp_valid_reg == 1'b0, "pop did not start head refill")
    `KWM_ASSERT_SAME(a_counts_ordered, clk, rst_n, 1'b1, counts_ok, "pop position beyond fill count")
    `KWM_ASSERT_SAME(a_no_overwrite, clk, rst_n, req_fire, !rsp_valid_reg || rsp.ready, "pending response would be overwritten")

endmodule
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import kwm_pkg::*;

    // Opcode the core has no use for; it must answer with an all-zero word
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         LONG_STALL  = 300;
    localparam int         PHASES      = 8;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic [2:0]         source_list;
        logic [1:0]         status;
    } merge_word_t;

    typedef enum logic {
        ROW_WORD,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic [1:0]         opcode;
        logic [2:0]         list_id;
        logic signed [31:0] value;
        int                 reps;
        bit                 typed;
        merge_word_t        want;
    } plan_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    kwm_req_if req_ch ();
    kwm_rsp_if rsp_ch ();
    kwm_cfg_if cfg_ch ();

    k_way_sorted_merge_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Mirror of the list stores, their counters and the active list count
    logic signed [VALUE_BITS-1:0] list_store [LISTS][LIST_DEPTH];
    int                           fill_count [LISTS];
    int                           pop_count  [LISTS];
    logic [3:0]                   active_setting = ACTIVE_RESET;

    merge_word_t        awaited_words [$];
    plan_row_t          directed_plan [$];
    logic signed [31:0] lane_base [LISTS];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stall_asked    = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int n_words        = 0;
    int n_appends      = 0;
    int n_pops         = 0;
    int n_clears       = 0;
    int n_full         = 0;
    int n_bad_list     = 0;
    int n_empty        = 0;
    int n_checked      = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 0;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Give up on a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // Work out the word the core should return, and advance the mirror
    function automatic merge_word_t predict_merge(input logic [1:0] op, input logic [2:0] id,
                                                  input logic signed [31:0] val);
        merge_word_t        res;
        int                 live;
        int                 best;
        bit                 found;
        logic signed [31:0] best_val;
        res      = '0;
        found    = 1'b0;
        best     = 0;
        best_val = '0;
        live     = (active_setting > LISTS) ? LISTS : int'(active_setting);
        case (op)
            OP_APPEND:
            begin
                if (int'(id) >= live)
                    res.status = ST_BAD_LIST;
                else if (fill_count[id] >= LIST_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    list_store[id][fill_count[id]] = val;
                    fill_count[id]++;
                end
            end
            OP_POP:
            begin
                // smallest head wins; on a tie the later list takes it
                for (int i = 0; i < live; i++)
                begin
                    if (pop_count[i] < fill_count[i])
                    begin
                        if (!found || list_store[i][pop_count[i]] <= best_val)
                        begin
                            found    = 1'b1;
                            best     = i;
                            best_val = list_store[i][pop_count[i]];
                        end
                    end
                end
                if (found)
                begin
                    pop_count[best]++;
                    res.value_out   = best_val;
                    res.source_list = best[2:0];
                end
                else
                    res.status = ST_EMPTY;
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < LISTS; i++)
                begin
                    fill_count[i] = 0;
                    pop_count[i]  = 0;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic add_row(input row_kind_t kind, input logic [1:0] op, input logic [2:0] id,
                           input logic signed [31:0] val, input int reps, input bit typed,
                           input logic signed [31:0] want_val, input logic [2:0] want_src,
                           input logic [1:0] want_st);
        plan_row_t row;
        row.kind             = kind;
        row.opcode           = op;
        row.list_id          = id;
        row.value            = val;
        row.reps             = reps;
        row.typed            = typed;
        row.want.value_out   = want_val;
        row.want.source_list = want_src;
        row.want.status      = want_st;
        directed_plan.insert(directed_plan.size(), row);
    endtask

    // Offer one request word, hold it until taken, then log what should come back
    task automatic push_word(input logic [1:0] op, input logic [2:0] id,
                             input logic signed [31:0] val, input bit typed,
                             input merge_word_t want);
        merge_word_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.opcode  <= op;
        req_ch.list_id <= id;
        req_ch.value   <= val;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = predict_merge(op, id, val);
        if (typed)
            predicted = want;
        awaited_words.insert(awaited_words.size(), predicted);
        n_words++;
        case (op)
            OP_APPEND: n_appends++;
            OP_POP:    n_pops++;
            OP_CLEAR:  n_clears++;
            default: ;
        endcase
        case (predicted.status)
            ST_FULL:     n_full++;
            ST_BAD_LIST: n_bad_list++;
            ST_EMPTY:    n_empty++;
            default: ;
        endcase
    endtask

    // Drain the core, then write the active list count
    task automatic write_active(input logic [3:0] setting);
        req_ch.valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= setting;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid   <= 1'b0;
        active_setting = setting;
    endtask

    // Mostly ascending appends per list, with noise, pops, the odd clear and unused opcodes
    task automatic run_merge_phase(input int n_items);
        logic [1:0]         op;
        logic [2:0]         id;
        logic signed [31:0] val;
        longint             step_val;
        int                 pick;
        int                 live;
        for (int k = 0; k < n_items; k++)
        begin
            live = (active_setting > LISTS) ? LISTS : int'(active_setting);
            pick = $urandom_range(0, 99);
            val  = $urandom;
            if (live > 0 && $urandom_range(0, 99) < 85)
                id = $urandom_range(0, live - 1);
            else
                id = $urandom_range(0, LISTS - 1);
            if (pick < 54)
            begin
                op = OP_APPEND;
                if ($urandom_range(0, 99) < 85)
                begin
                    step_val = longint'(lane_base[id]) + longint'($urandom_range(0, 4000));
                    if (step_val <= longint'(32'sh7fffffff))
                        val = step_val[31:0];
                    lane_base[id] = val;
                end
            end
            else if (pick < 97)
                op = OP_POP;
            else if (pick == 97)
            begin
                op = OP_CLEAR;
                for (int i = 0; i < LISTS; i++)
                    lane_base[i] = $signed($urandom) >>> 1;
            end
            else
                op = OP_UNUSED;
            push_word(op, id, val, 1'b0, '0);
        end
    endtask

    // Response side: random or long back-pressure, and the field checks
    initial
    begin
        merge_word_t want;
        int          hold_left;
        int          stall_served;
        hold_left    = 0;
        stall_served = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_words.size() == 0)
                begin
                    $error("response word with nothing awaited: value_out %0d source_list %0d status %0d",
                           rsp_ch.value_out, rsp_ch.source_list, rsp_ch.status);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_words.pop_front();
                    n_checked++;
                    if (rsp_ch.value_out !== want.value_out)
                    begin
                        $error("value_out: expected %0d, got %0d", want.value_out,
                               rsp_ch.value_out);
                        mismatch_count++;
                    end
                    if (rsp_ch.source_list !== want.source_list)
                    begin
                        $error("source_list: expected %0d, got %0d", want.source_list,
                               rsp_ch.source_list);
                        mismatch_count++;
                    end
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        mismatch_count++;
                    end
                end
            end
            if (stall_served != stall_asked)
            begin
                stall_served = stall_asked;
                hold_left    = LONG_STALL;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Stimulus
    initial
    begin
        logic [3:0] phase_setting [PHASES];
        int         phase_items   [PHASES];
        req_ch.valid   <= 1'b0;
        req_ch.opcode  <= OP_APPEND;
        req_ch.list_id <= '0;
        req_ch.value   <= '0;
        cfg_ch.valid   <= 1'b0;
        cfg_ch.data    <= ACTIVE_RESET;
        phase_setting = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd0, 4'd6, 4'd2, 4'd8};
        phase_items   = '{230, 200, 200, 200, 60, 200, 200, 210};
        for (int i = 0; i < LISTS; i++)
        begin
            fill_count[i] = 0;
            pop_count[i]  = 0;
            lane_base[i]  = $signed($urandom) >>> 1;
        end

        // Directed rows: empty start, extremes, ties, unsorted list, full list,
        // unused opcode, inactive lists and out-of-range settings
        add_row(ROW_WORD, OP_POP, 3'd0, 0, 1, 1, 0, 3'd0, ST_EMPTY);
        add_row(ROW_WORD, OP_APPEND, 3'd0, 32'sh7fffffff, 1, 1, 0, 3'd0, ST_OK);
        add_row(ROW_WORD, OP_APPEND, 3'd7, 32'sh80000000, 1, 1, 0, 3'd0, ST_OK);
        add_row(ROW_WORD, OP_APPEND, 3'd3, 0, 1, 1, 0, 3'd0, ST_OK);
        add_row(ROW_WORD, OP_APPEND, 3'd3, 0, 1, 0, 0, 3'd0, ST_OK);
        add_row(ROW_WORD, OP_APPEND, 3'd5, 0, 1, 0, 0, 3'd0, ST_OK);
        add_row(ROW_WORD, OP_UNUSED, 3'd7, -1, 1, 1, 0, 3'd0, ST_OK);
        add_row(ROW_WORD, OP_POP, 3'd0, 0, 1, 1, 32'sh80000000, 3'd7, ST_OK);
        add_row(ROW_WORD, OP_POP, 3'd0, 0, 3, 0, 0, 3'd0, ST_OK);
        add_row(ROW_WORD, OP_POP, 3'd0, 0, 1, 1, 32'sh7fffffff, 3'd0, ST_OK);
        add_row(ROW_WORD, OP_POP, 3'd0, 0, 1, 1, 0, 3'd0, ST_EMPTY);
        add_row(ROW_WORD, OP_APPEND, 3'd2, 100, 1, 0, 0, 3'd0, ST_OK);
        add_row(ROW_WORD, OP_APPEND, 3'd2, -100, 1, 0, 0, 3'd0, ST_OK);
        add_row(ROW_WORD, OP_POP, 3'd0, 0, 1, 0, 0, 3'd0, ST_OK);
        add_row(ROW_WORD, OP_APPEND, 3'd1, 32'sh55555555, LIST_DEPTH, 0, 0, 3'd0, ST_OK);
        add_row(ROW_WORD, OP_APPEND, 3'd1, 32'shaaaaaaaa, 1, 1, 0, 3'd0, ST_FULL);
        add_row(ROW_WORD, OP_POP, 3'd0, 0, 2, 0, 0, 3'd0, ST_OK);
        add_row(ROW_WORD, OP_CLEAR, 3'd0, 0, 1, 1, 0, 3'd0, ST_OK);
        add_row(ROW_WORD, OP_POP, 3'd0, 0, 1, 1, 0, 3'd0, ST_EMPTY);
        add_row(ROW_CFG, OP_APPEND, 3'd0, 1, 1, 0, 0, 3'd0, ST_OK);
        add_row(ROW_WORD, OP_APPEND, 3'd1, 5, 1, 1, 0, 3'd0, ST_BAD_LIST);
        add_row(ROW_WORD, OP_APPEND, 3'd0, -1, 1, 1, 0, 3'd0, ST_OK);
        add_row(ROW_CFG, OP_APPEND, 3'd0, 0, 1, 0, 0, 3'd0, ST_OK);
        add_row(ROW_WORD, OP_APPEND, 3'd0, 7, 1, 1, 0, 3'd0, ST_BAD_LIST);
        add_row(ROW_WORD, OP_POP, 3'd0, 0, 1, 1, 0, 3'd0, ST_EMPTY);
        add_row(ROW_CFG, OP_APPEND, 3'd0, 15, 1, 0, 0, 3'd0, ST_OK);
        add_row(ROW_WORD, OP_POP, 3'd0, 0, 1, 1, -1, 3'd0, ST_OK);
        add_row(ROW_WORD, OP_CLEAR, 3'd0, 0, 1, 1, 0, 3'd0, ST_OK);

        do
            @(posedge clk);
        while (rst_n !== 1'b1);
        @(posedge clk);

        // Walk the directed table
        foreach (directed_plan[r])
        begin
            if (directed_plan[r].kind == ROW_CFG)
                write_active(directed_plan[r].value[3:0]);
            else
            begin
                for (int k = 0; k < directed_plan[r].reps; k++)
                    push_word(directed_plan[r].opcode, directed_plan[r].list_id,
                              directed_plan[r].value + k, directed_plan[r].typed,
                              directed_plan[r].want);
            end
        end

        // Random phases, each under its own setting and idling pattern
        for (int p = 0; p < PHASES; p++)
        begin
            write_active(phase_setting[p]);
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 45;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 45;
                end
                default:
                begin
                    send_idle_pct  = 36;
                    recv_stall_pct = 36;
                end
            endcase
            if (p == 2 || p == 5)
                stall_asked++;
            run_merge_phase(phase_items[p]);
        end

        // Drain and report
        req_ch.valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Run covered %0d request words: %0d appends, %0d pops, %0d clears",
                 n_words, n_appends, n_pops, n_clears);
        $display("%0d responses checked: %0d full-list drops, %0d bad-list drops, %0d empty pops",
                 n_checked, n_full, n_bad_list, n_empty);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
